// File: hdl/aesrk_pkg.sv
// ----------------------------------------------------------------------------
// AES-128 round key step - shared definitions
// Command codes, the item carried between the stages, the S-box and the
// round constants of the AES-128 key schedule.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package aesrk_pkg;

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_NEXT = 2'd1,
    CMD_PREV = 2'd2
  } aesrk_cmd_e;

  // One registered item waiting for the key update.
  typedef struct packed {
    logic [1:0]   command;
    logic [127:0] key;
    logic [3:0]   round_index;
  } aesrk_item_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  // Round constants; indexes past the tenth round give zero.
  localparam logic [7:0] RCON [16] = '{
    8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80,
    8'h1b, 8'h36, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  // SubWord(RotWord(w)) xor rcon in the top byte.
  function automatic logic [31:0] sched_term(input logic [31:0] w, input logic [3:0] rnd);
    logic [31:0] rot;
    rot = {w[23:0], w[31:24]};
    return {SBOX[rot[31:24]] ^ RCON[rnd], SBOX[rot[23:16]],
            SBOX[rot[15:8]], SBOX[rot[7:0]]};
  endfunction

endpackage

// File: hdl/aesrk_step.sv
// ----------------------------------------------------------------------------
// AES-128 round key step - key update logic
// Forms the next key from the held key and one item: load, forward step,
// backward step, or hold for the unused code.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aesrk_step
  import aesrk_pkg::*;
(
  input  aesrk_item_t  item_i,
  input  logic [127:0] key_i,
  output logic [127:0] key_o
);

  logic [31:0] w0, w1, w2, w3;
  logic [31:0] term_in;
  logic [31:0] term;

  assign w0 = key_i[127:96];
  assign w1 = key_i[95:64];
  assign w2 = key_i[63:32];
  assign w3 = key_i[31:0];

  // One schedule term serves both directions: backward uses the restored w3.
  assign term_in = (item_i.command == CMD_PREV) ? (w3 ^ w2) : w3;
  assign term    = sched_term(term_in, item_i.round_index);

  always_comb begin
    case (item_i.command)
      CMD_LOAD: begin
        key_o = item_i.key;
      end
      CMD_NEXT: begin
        key_o[127:96] = w0 ^ term;
        key_o[95:64]  = w1 ^ w0 ^ term;
        key_o[63:32]  = w2 ^ w1 ^ w0 ^ term;
        key_o[31:0]   = w3 ^ w2 ^ w1 ^ w0 ^ term;
      end
      CMD_PREV: begin
        key_o[127:96] = w0 ^ term;
        key_o[95:64]  = w1 ^ w0;
        key_o[63:32]  = w2 ^ w1;
        key_o[31:0]   = w3 ^ w2;
      end
      default: begin
        key_o = key_i;
      end
    endcase
  end

endmodule

// File: hdl/aes128_round_key_step.sv
// ----------------------------------------------------------------------------
// AES-128 round key step - top level
// An accepted input passes through the input register, then the key and result
// register. Throughput: one item per cycle while the result side is not stalled.
// The held key is updated in the same edge that loads the result register.
// Reset clears the held key to zero and empties both register stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aes128_round_key_step
  import aesrk_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  // input channel
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  logic [1:0]   command_i,
  input  logic [63:0]  key_high_i,
  input  logic [63:0]  key_low_i,
  input  logic [3:0]   round_index_i,
  // result channel
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output logic [63:0]  round_key_high_o,
  output logic [63:0]  round_key_low_o
);

  // Input stage
  aesrk_item_t  item_q;
  logic         item_valid_q;
  logic         in_accept;

  // Key state and result stage
  logic [127:0] key_q;
  logic [127:0] key_d;
  logic [127:0] result_q;
  logic         out_valid_q;

  logic         stage_adv;   // result register can take a new item
  logic         item_fire;   // input stage item moves into the key / result

  // Advance whenever the result register is empty or being drained.
  assign stage_adv  = !out_valid_q || !out_stall_i;
  assign item_fire  = item_valid_q && stage_adv;
  assign in_stall_o = item_valid_q && !stage_adv;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Capture the item; hold it while the result side is stalled.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_accept) begin
      item_valid_q <= 1'b1;
    end else if (item_fire) begin
      item_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q.command     <= command_i;
      item_q.key         <= {key_high_i, key_low_i};
      item_q.round_index <= round_index_i;
    end
  end

  // Key schedule step on the held key.
  aesrk_step u_step (
    .item_i (item_q),
    .key_i  (key_q),
    .key_o  (key_d)
  );

  // Advance the held key only when the item leaves the input stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else if (item_fire) begin
      key_q <= key_d;
    end
  end

  // Result register: fill on fire, drop once taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (item_fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_fire) begin
      result_q <= key_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign round_key_high_o = result_q[127:64];
  assign round_key_low_o  = result_q[63:0];

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------

  // A full input stage behind a stalled result must push back.
  a_stall_backpressure : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    item_valid_q && out_valid_q && out_stall_i |-> in_stall_o
  ) else $error("input stage not stalled behind a stalled result");

  // The result shown is the key that was just stored.
  a_result_matches_key : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    item_fire |=> out_valid_o && (result_q == key_q)
  ) else $error("result register does not match held key");

  // A load replaces the held key with the item's key.
  a_load_key : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    item_fire && (item_q.command == CMD_LOAD) |=> key_q == $past(item_q.key)
  ) else $error("load did not take the new key");

  // The held key only changes when an item moves through.
  a_key_stable : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !item_fire |=> $stable(key_q)
  ) else $error("held key changed without an item");

endmodule
